// ----- hdl/clock_frame_replacement_unit_defines.svh -----
// Assertion macros used by the checker file of the frame replacement unit.
// Depends on a clk_i and an active-low rst_ni in the scope that uses them.
`ifndef CLOCK_FRAME_REPLACEMENT_UNIT_DEFINES_SVH
`define CLOCK_FRAME_REPLACEMENT_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame replacement check failed");

// next-cycle implication, checked outside reset
`define CFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame replacement check failed");

`endif

// ----- hdl/cfr_pkg.sv -----
`timescale 1ns / 1ps
// Types, codes and sizes of the clock frame replacement unit.
// No dependencies; used by the top level and the checker.
package cfr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_AW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int GRP_SIZE   = 8;
  localparam int GROUPS     = (NUM_FRAMES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int ENTRY_W    = 2;

  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_PIN    = 3'd2;
  localparam logic [2:0] MODE_UNPIN  = 3'd3;
  localparam logic [2:0] MODE_ACCESS = 3'd4;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_IN_USE = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAME   = 2'd2;

  typedef logic [FRAME_AW-1:0] frame_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] frame_index;
  } cfr_req_t;

  typedef struct packed {
    logic [5:0] result_frame;
    logic [1:0] status;
    logic       evicted;
  } cfr_rsp_t;

  // per-frame flags kept in the frame memory
  typedef struct packed {
    logic pinned;
    logic accessed;
  } cfr_entry_t;

endpackage

// ----- hdl/cfr_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/clock_frame_replacement_unit.sv -----
`timescale 1ns / 1ps
// Frame table with clock (second-chance) replacement.
// Depends on cfr_pkg and cfr_ram.
//
// A request is taken when start is high and busy is low; its single result is
// shown on rsp_o for one cycle with done_o high, and the receiver cannot stall.
// Pinned and accessed flags live in a one-read, one-write RAM; the in-use bits
// live in flops and feed a registered lowest-free-frame search. An unknown
// mode or a frame not in use is answered straight from idle; free, pin, unpin
// and access read the flags, then write them back; an allocation takes a free
// frame if the search shows one, answers no-frame if every frame is pinned,
// and else sweeps from the hand, one RAM read per cycle, until it evicts a frame.
// busy is low again in the cycle done_o is shown.
module clock_frame_replacement_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cfr_pkg::cfr_req_t req_i,
  output logic              done_o,
  output cfr_pkg::cfr_rsp_t rsp_o
);
  import cfr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RMW   = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]            state_q, state_d;
  cfr_req_t              req_q, req_d;
  frame_t                hand_q, hand_d;
  frame_t                pos_q, pos_d;
  logic [NUM_FRAMES-1:0] in_use_q, in_use_d;
  logic [CNT_W-1:0]      pin_cnt_q, pin_cnt_d;
  cfr_rsp_t              rsp_q, rsp_d;
  logic                  done_q, done_d;

  logic                  grp_free_q [GROUPS];
  logic [2:0]            grp_local_q [GROUPS];
  logic                  grp_free_d [GROUPS];
  logic [2:0]            grp_local_d [GROUPS];
  logic [GROUPS*GRP_SIZE-1:0] pad_used;

  logic                  ram_we;
  frame_t                ram_waddr;
  cfr_entry_t            ram_wdata;
  frame_t                ram_raddr;
  cfr_entry_t            ram_rdata;

  frame_t                idx_in;
  frame_t                idx_req;
  logic                  idx_ok;
  frame_t                pos_next;
  logic                  found;
  frame_t                found_frame;

  cfr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_FRAMES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // First stage of the free-frame search: lowest free slot within each group.
  always_comb begin
    pad_used = '1;
    pad_used[NUM_FRAMES-1:0] = in_use_q;
    for (int g = 0; g < GROUPS; g++) begin
      grp_free_d[g]  = 1'b0;
      grp_local_d[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (!pad_used[g*GRP_SIZE + b]) begin
          grp_free_d[g]  = 1'b1;
          grp_local_d[g] = 3'(b);
        end
      end
    end
  end

  // Second stage: lowest group with a free slot.
  always_comb begin
    found       = 1'b0;
    found_frame = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        found       = 1'b1;
        found_frame = FRAME_AW'(g * GRP_SIZE + int'(grp_local_q[g]));
      end
    end
  end

  assign idx_in   = FRAME_AW'(req_i.frame_index);
  assign idx_req  = FRAME_AW'(req_q.frame_index);
  assign idx_ok   = int'(req_i.frame_index) < NUM_FRAMES;
  assign pos_next = (pos_q == FRAME_AW'(NUM_FRAMES - 1)) ? '0 : pos_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    hand_d    = hand_q;
    pos_d     = pos_q;
    in_use_d  = in_use_q;
    pin_cnt_d = pin_cnt_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = '0;
    ram_raddr = pos_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          priority if (req_i.mode == MODE_ALLOC) begin
            state_d = ST_ALLOC;
          end else if (req_i.mode > MODE_ACCESS) begin
            rsp_d  = '{result_frame: req_i.frame_index, status: STATUS_OK, evicted: 1'b0};
            done_d = 1'b1;
          end else if (!idx_ok || !in_use_q[idx_in]) begin
            rsp_d  = '{result_frame: req_i.frame_index, status: STATUS_NOT_IN_USE,
                       evicted: 1'b0};
            done_d = 1'b1;
          end else begin
            ram_raddr = idx_in;
            state_d   = ST_RMW;
          end
        end
      end

      ST_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = idx_req;
        unique case (req_q.mode)
          MODE_FREE: begin
            in_use_d[idx_req] = 1'b0;
            ram_wdata         = '0;
            if (ram_rdata.pinned) begin
              pin_cnt_d = pin_cnt_q - 1'b1;
            end
          end
          MODE_PIN: begin
            ram_wdata = '{pinned: 1'b1, accessed: ram_rdata.accessed};
            if (!ram_rdata.pinned) begin
              pin_cnt_d = pin_cnt_q + 1'b1;
            end
          end
          MODE_UNPIN: begin
            ram_wdata = '{pinned: 1'b0, accessed: ram_rdata.accessed};
            if (ram_rdata.pinned) begin
              pin_cnt_d = pin_cnt_q - 1'b1;
            end
          end
          default: begin
            ram_wdata = '{pinned: ram_rdata.pinned, accessed: 1'b1};
          end
        endcase
        rsp_d   = '{result_frame: req_q.frame_index, status: STATUS_OK, evicted: 1'b0};
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_ALLOC: begin
        priority if (found) begin
          in_use_d[found_frame] = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = found_frame;
          ram_wdata = '0;
          rsp_d     = '{result_frame: 6'(found_frame), status: STATUS_OK, evicted: 1'b0};
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else if (pin_cnt_q == CNT_W'(NUM_FRAMES)) begin
          rsp_d   = '{result_frame: 6'd0, status: STATUS_NO_FRAME, evicted: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ram_raddr = hand_q;
          pos_d     = hand_q;
          state_d   = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        // ram_rdata holds the flags of the frame at the sweep position pos_q
        if (!ram_rdata.pinned && !ram_rdata.accessed) begin
          hand_d  = pos_next;
          rsp_d   = '{result_frame: 6'(pos_q), status: STATUS_OK, evicted: 1'b1};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // clear the second chance of an unpinned frame, then advance the sweep position
          if (!ram_rdata.pinned) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q;
            ram_wdata = '0;
          end
          ram_raddr = pos_next;
          pos_d     = pos_next;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hand_q    <= '0;
      in_use_q  <= '0;
      pin_cnt_q <= '0;
      done_q    <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        grp_free_q[g]  <= 1'b0;
        grp_local_q[g] <= '0;
      end
    end else begin
      state_q   <= state_d;
      hand_q    <= hand_d;
      in_use_q  <= in_use_d;
      pin_cnt_q <= pin_cnt_d;
      done_q    <= done_d;
      for (int g = 0; g < GROUPS; g++) begin
        grp_free_q[g]  <= grp_free_d[g];
        grp_local_q[g] <= grp_local_d[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    pos_q <= pos_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- hdl/cfr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the clock frame replacement unit, bound to the top level.
// Depends on cfr_pkg and clock_frame_replacement_unit_defines.svh.
`include "clock_frame_replacement_unit_defines.svh"

module cfr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input cfr_pkg::cfr_rsp_t rsp_o
);
  import cfr_pkg::*;

  // every beat taken either keeps the unit busy or answers in the next cycle
  `CFR_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o)

  // a result only follows an accepted beat or a busy cycle
  `CFR_ASSERT_NOW(a_done_has_cause, done_o, $past(busy) || $past(start))

  // eviction is always a successful allocation
  `CFR_ASSERT_NOW(a_evict_ok, done_o && rsp_o.evicted, rsp_o.status == STATUS_OK)

  // a no-frame answer names frame zero and evicts nothing
  `CFR_ASSERT_NOW(a_no_frame_shape, done_o && (rsp_o.status == STATUS_NO_FRAME),
    (rsp_o.result_frame == 6'd0) && !rsp_o.evicted)

endmodule

bind clock_frame_replacement_unit cfr_checker u_cfr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ----- bench/clock_frame_replacement_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the clock frame replacement unit: directed and random requests,
// each reply checked against an in-bench model of the frame table and clock hand.
// Depends on cfr_pkg and clock_frame_replacement_unit.
module clock_frame_replacement_unit_tb;
  import cfr_pkg::*;

  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * NUM_FRAMES + 8;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  cfr_req_t req_i  = '0;
  logic     busy;
  logic     done_o;
  cfr_rsp_t rsp_o;

  // model of the frame table
  bit [NUM_FRAMES-1:0] frame_used;
  bit [NUM_FRAMES-1:0] frame_pinned;
  bit [NUM_FRAMES-1:0] frame_touched;
  int                  model_hand;

  cfr_rsp_t pending_replies[$];
  cfr_rsp_t want;
  int       sender_idle_pct;
  int       requests_sent;
  int       mismatches;
  int       evictions_seen;
  int       no_frame_seen;
  int       not_in_use_seen;
  int       cycle_count;

  clock_frame_replacement_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d replies outstanding",
               CYCLE_LIMIT, pending_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Apply one request to the frame table model and return the reply it earns.
  function automatic cfr_rsp_t predict_frame_reply(cfr_req_t rq);
    cfr_rsp_t r;
    bit       found;
    int       pos;
    r.result_frame = rq.frame_index;
    r.status       = STATUS_OK;
    r.evicted      = 1'b0;
    found          = 1'b0;
    case (rq.mode)
      MODE_ALLOC: begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!found && !frame_used[i]) begin
            found            = 1'b1;
            frame_used[i]    = 1'b1;
            frame_pinned[i]  = 1'b0;
            frame_touched[i] = 1'b0;
            r.result_frame   = 6'(i);
          end
        end
        if (!found && frame_pinned == '1) begin
          r.result_frame = '0;
          r.status       = STATUS_NO_FRAME;
        end else if (!found) begin
          pos = model_hand;
          // sweep: skip pinned, give accessed frames a second chance
          for (int k = 0; k < 2 * NUM_FRAMES && !found; k++) begin
            if (!frame_pinned[pos]) begin
              if (!frame_touched[pos]) begin
                found          = 1'b1;
                model_hand     = (pos + 1) % NUM_FRAMES;
                r.result_frame = 6'(pos);
                r.evicted      = 1'b1;
              end else begin
                frame_touched[pos] = 1'b0;
              end
            end
            if (!found) pos = (pos + 1) % NUM_FRAMES;
          end
        end
      end
      MODE_FREE, MODE_PIN, MODE_UNPIN, MODE_ACCESS: begin
        if (!frame_used[rq.frame_index]) begin
          r.status = STATUS_NOT_IN_USE;
        end else begin
          case (rq.mode)
            MODE_FREE: begin
              frame_used[rq.frame_index]    = 1'b0;
              frame_pinned[rq.frame_index]  = 1'b0;
              frame_touched[rq.frame_index] = 1'b0;
            end
            MODE_PIN:   frame_pinned[rq.frame_index] = 1'b1;
            MODE_UNPIN: frame_pinned[rq.frame_index] = 1'b0;
            default:    frame_touched[rq.frame_index] = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Present one beat and hold it until the block takes it.
  task automatic send_request(logic [2:0] mode, logic [5:0] idx);
    cfr_req_t rq;
    rq.mode        = mode;
    rq.frame_index = idx;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    pending_replies.push_back(predict_frame_reply(rq));
    requests_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply beat, frame", int'(rsp_o.result_frame), -1);
      end else begin
        want = pending_replies.pop_front();
        if (rsp_o.result_frame !== want.result_frame)
          report_mismatch("result_frame", int'(rsp_o.result_frame),
                          int'(want.result_frame));
        if (rsp_o.status !== want.status)
          report_mismatch("status", int'(rsp_o.status), int'(want.status));
        if (rsp_o.evicted !== want.evicted)
          report_mismatch("evicted", int'(rsp_o.evicted), int'(want.evicted));
        if (want.evicted) evictions_seen++;
        if (want.status == STATUS_NO_FRAME) no_frame_seen++;
        if (want.status == STATUS_NOT_IN_USE) not_in_use_seen++;
      end
    end
  end

  function automatic logic [5:0] pick_used_frame();
    int first;
    first = $urandom_range(NUM_FRAMES - 1);
    for (int k = 0; k < NUM_FRAMES; k++)
      if (frame_used[(first + k) % NUM_FRAMES]) return 6'((first + k) % NUM_FRAMES);
    return 6'(first);
  endfunction

  // Field extremes, every mode, spare modes and frames not in use, from an empty table.
  task automatic test_directed();
    send_request(MODE_SPARE_A, 6'd63);
    send_request(MODE_SPARE_B, 6'd0);
    send_request(MODE_SPARE_C, 6'd42);
    send_request(MODE_FREE, 6'd63);
    send_request(MODE_PIN, 6'd0);
    send_request(MODE_UNPIN, 6'd21);
    send_request(MODE_ACCESS, 6'd63);
    send_request(MODE_ALLOC, 6'd63);
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_ALLOC, 6'd21);
    send_request(MODE_PIN, 6'd0);
    send_request(MODE_ACCESS, 6'd1);
    send_request(MODE_UNPIN, 6'd0);
    send_request(MODE_ACCESS, 6'd0);
    send_request(MODE_PIN, 6'd1);
    send_request(MODE_FREE, 6'd1);
    send_request(MODE_ALLOC, 6'd42);
    send_request(MODE_FREE, 6'd0);
    send_request(MODE_FREE, 6'd0);
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_SPARE_A, 6'd1);
  endtask

  // Fill and pin the whole table, then reopen it one frame at a time.
  task automatic test_all_pinned();
    int first;
    int lone;
    while (frame_used != '1) send_request(MODE_ALLOC, 6'($urandom_range(63)));
    first = $urandom_range(NUM_FRAMES - 1);
    for (int k = 0; k < NUM_FRAMES; k++)
      send_request(MODE_PIN, 6'((first + k) % NUM_FRAMES));
    send_request(MODE_ALLOC, 6'd0);
    send_request(MODE_ALLOC, 6'd63);
    // lone candidate just behind the hand, accessed: longest sweep
    lone = (model_hand + NUM_FRAMES - 1) % NUM_FRAMES;
    send_request(MODE_ACCESS, 6'(lone));
    send_request(MODE_UNPIN, 6'(lone));
    send_request(MODE_ALLOC, 6'($urandom_range(63)));
    send_request(MODE_ACCESS, 6'(lone));
    send_request(MODE_ALLOC, 6'($urandom_range(63)));
    first = $urandom_range(NUM_FRAMES - 1);
    for (int k = 0; k < NUM_FRAMES; k++) begin
      send_request(MODE_UNPIN, 6'((first + k) % NUM_FRAMES));
      send_request(MODE_ACCESS, 6'((first + k) % NUM_FRAMES));
    end
    repeat (4) send_request(MODE_ALLOC, 6'($urandom_range(63)));
  endtask

  // Mostly well-formed requests on frames in use, the rest noise.
  task automatic run_random_traffic(int count, int idle_pct);
    int sel;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 30)      send_request(MODE_ALLOC, 6'($urandom_range(63)));
      else if (sel < 55) send_request(MODE_ACCESS, pick_used_frame());
      else if (sel < 65) send_request(MODE_PIN, pick_used_frame());
      else if (sel < 75) send_request(MODE_UNPIN, pick_used_frame());
      else if (sel < 85) send_request(MODE_FREE, pick_used_frame());
      else               send_request(3'($urandom_range(7)), 6'($urandom_range(63)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 18;
    test_directed();
    test_all_pinned();
    run_random_traffic(155, 18);
    run_random_traffic(155, 56);
    run_random_traffic(155, 0);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests over three idle profiles, including a fully pinned table.",
             requests_sent);
    $display("Replies: %0d evictions, %0d no-frame, %0d not-in-use; %0d mismatches.",
             evictions_seen, no_frame_seen, not_in_use_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
